/* src/rmsprop_weight_update_macros.svh */
// Assertion macros for the RMSProp weight update block.
// Included by the top level; no other dependencies.
`ifndef RMSPROP_WEIGHT_UPDATE_MACROS_SVH
`define RMSPROP_WEIGHT_UPDATE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define RMSW_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled during reset.
`define RMSW_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RMSW_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define RMSW_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

/* src/rmsw_pkg.sv */
// Shared types, constants and arithmetic step functions of the RMSProp block.
// No dependencies.
`timescale 1ns / 1ps

package rmsw_pkg;

  // Default store depth and register reset values.
  localparam int STORE_DEPTH_DEF = 4096;
  localparam logic [15:0] DECAY_RESET = 16'd58982;
  localparam logic [31:0] EPS_RESET = 32'd1;
  localparam logic [23:0] LR_RESET = 24'd16777;

  // Pipeline depths of the iterative units, two digits per stage.
  localparam int SQRT_STAGES = 14;
  localparam int DIV_STAGES = 28;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_DECAY = 2'd0,
    REG_EPS   = 2'd1,
    REG_LR    = 2'd2
  } reg_idx_t;

  // Per-request data that travels beside the arithmetic.
  typedef struct packed {
    logic [31:0] weight;
    logic        neg;
    logic [31:0] mag;
    logic [11:0] idx;
    logic        last;
    logic        div_zero;
    logic        num_zero;
  } side_t;

  // Status of the mean-square front end.
  typedef struct packed {
    logic clearing;
  } msq_stat_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [27:0] root;
  } sq_t;

  typedef struct packed {
    logic [32:0] rem;
    logic [55:0] quo;
  } dv_t;

  // One digit of the integer square root.
  function automatic sq_t sqrt_step(input sq_t cur, input logic [1:0] pair);
    logic [31:0] r2;
    logic [31:0] trial;
    sq_t res;
    r2 = {cur.rem[29:0], pair};
    trial = {2'b00, cur.root, 2'b01};
    if (r2 >= trial) begin
      res.rem = r2 - trial;
      res.root = {cur.root[26:0], 1'b1};
    end else begin
      res.rem = r2;
      res.root = {cur.root[26:0], 1'b0};
    end
    return res;
  endfunction

  // One bit of restoring division; the dividend shifts out of quo as
  // quotient bits shift in.
  function automatic dv_t div_step(input dv_t cur, input logic [32:0] d);
    logic [33:0] r2;
    dv_t res;
    r2 = {cur.rem, cur.quo[55]};
    if (r2 >= {1'b0, d}) begin
      res.rem = 33'(r2 - {1'b0, d});
      res.quo = {cur.quo[54:0], 1'b1};
    end else begin
      res.rem = r2[32:0];
      res.quo = {cur.quo[54:0], 1'b0};
    end
    return res;
  endfunction

endpackage

/* src/rmsw_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rmsw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

/* src/rmsw_msq.sv */
// Front end: gradient square, mean-square store with forwarding and the
// post-reset clearing pass. Depends on rmsw_pkg and rmsw_ram.
`timescale 1ns / 1ps

module rmsw_msq #(
  parameter int STORE_DEPTH = rmsw_pkg::STORE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [11:0]       in_element_index,
  input  logic [31:0]       in_weight_in,
  input  logic [31:0]       in_gradient,
  input  logic              in_fresh,
  input  logic              in_last_element,
  input  logic [15:0]       decay_rate,
  output logic              msq_valid,
  output logic [31:0]       msq_square,
  output rmsw_pkg::side_t   msq_side,
  output rmsw_pkg::msq_stat_t stat
);
  import rmsw_pkg::*;

  localparam int SLOT_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(STORE_DEPTH - 1);

  logic              acc;
  logic [SLOT_W-1:0] slot_in;
  logic [31:0]       mag_in;
  logic              clearing_r;
  logic [SLOT_W-1:0] clr_idx_r;

  logic              v1_r, v2_r, v3_r;
  side_t             side1_r, side2_r, side3_r;
  logic [63:0]       prod1_r;
  logic              fresh1_r;
  logic [SLOT_W-1:0] slot1_r, slot2_r;
  logic              byp1_r;
  logic [31:0]       bypd1_r;
  logic [31:0]       gsq2_r, old2_r, s3_r;
  logic [31:0]       old1, gsq1, s_new, ram_rdata;
  logic [49:0]       sum2;
  logic              wr;
  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  logic [31:0]       ram_wdata;

  // Reduce the index into the store.
  generate
    if (STORE_DEPTH >= 4096) begin : g_slot_direct
      assign slot_in = SLOT_W'(in_element_index);
    end else begin : g_slot_recip
      localparam logic [39:0] RECIP = 40'((2**24 + STORE_DEPTH - 1) / STORE_DEPTH);
      localparam logic [12:0] DEP = 13'(STORE_DEPTH);
      logic [39:0] prod_q;
      logic [11:0] quo;
      logic [24:0] back;
      logic [12:0] rem;
      always_comb begin
        prod_q = {28'b0, in_element_index} * RECIP;
        quo = prod_q[35:24];
        back = {13'b0, quo} * {12'b0, DEP};
        rem = {1'b0, in_element_index} - back[12:0];
        if (rem >= DEP) begin
          rem = rem - DEP;
        end
      end
      assign slot_in = SLOT_W'(rem);
    end
  endgenerate

  assign in_ready = adv && !clearing_r;
  assign acc = in_valid && in_ready;
  assign mag_in = in_gradient[31] ? 32'(-in_gradient) : in_gradient;
  assign stat.clearing = clearing_r;

  // Clearing pass after reset: one entry per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_idx_r <= '0;
    end else if (clearing_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (clr_idx_r == LAST_SLOT) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // Store write: zeros while clearing, else the updated mean square.
  assign wr = adv && v2_r;
  assign ram_we = clearing_r || wr;
  assign ram_waddr = clearing_r ? clr_idx_r : slot2_r;
  assign ram_wdata = clearing_r ? 32'd0 : s_new;

  rmsw_ram #(
    .WIDTH(32),
    .DEPTH(STORE_DEPTH),
    .AW(SLOT_W)
  ) u_store (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .re     (acc),
    .raddr  (slot_in),
    .rdata_r(ram_rdata)
  );

  // Valid bits of the three front stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= acc;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Stage 1: square the gradient, capture a write that hits the read slot.
  always_ff @(posedge clk) begin
    if (adv) begin
      side1_r.weight <= in_weight_in;
      side1_r.neg <= in_gradient[31];
      side1_r.mag <= mag_in;
      side1_r.idx <= in_element_index;
      side1_r.last <= in_last_element;
      side1_r.div_zero <= 1'b0;
      side1_r.num_zero <= 1'b0;
      prod1_r <= {32'b0, mag_in} * {32'b0, mag_in};
      fresh1_r <= in_fresh;
      slot1_r <= slot_in;
      byp1_r <= wr && (slot2_r == slot_in);
      bypd1_r <= s_new;
    end
  end

  assign old1 = byp1_r ? bypd1_r : ram_rdata;
  assign gsq1 = (|prod1_r[63:56]) ? 32'hFFFF_FFFF : prod1_r[55:24];

  // Stage 2: pick the old mean square, forwarding the write ahead of it.
  always_ff @(posedge clk) begin
    if (adv) begin
      side2_r <= side1_r;
      slot2_r <= slot1_r;
      gsq2_r <= gsq1;
      if (fresh1_r) begin
        old2_r <= 32'd0;
      end else if (wr && (slot2_r == slot1_r)) begin
        old2_r <= s_new;
      end else begin
        old2_r <= old1;
      end
    end
  end

  // Blend old mean square and new square.
  assign sum2 = 50'({16'b0, decay_rate} * {16'b0, old2_r})
              + 50'((17'h10000 - {1'b0, decay_rate}) * {17'b0, gsq2_r});
  assign s_new = (|sum2[49:48]) ? 32'hFFFF_FFFF : sum2[47:16];

  // Stage 3: registered mean square.
  always_ff @(posedge clk) begin
    if (adv) begin
      side3_r <= side2_r;
      s3_r <= s_new;
    end
  end

  assign msq_valid = v3_r;
  assign msq_square = s3_r;
  assign msq_side = side3_r;

endmodule

/* src/rmsw_sqrt.sv */
// Pipelined integer square root of the mean square in Q8.24, two digits
// per stage. Depends on rmsw_pkg.
`timescale 1ns / 1ps

module rmsw_sqrt (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            sq_in_valid,
  input  logic [31:0]     sq_in_square,
  input  rmsw_pkg::side_t sq_in_side,
  output logic            sq_valid,
  output logic [27:0]     sq_root,
  output rmsw_pkg::side_t sq_side
);
  import rmsw_pkg::*;

  logic        v_r    [0:SQRT_STAGES];
  sq_t         st_r   [0:SQRT_STAGES];
  logic [55:0] xs_r   [0:SQRT_STAGES];
  side_t       side_r [0:SQRT_STAGES];

  // Load stage: the radicand is the mean square shifted up by 24 bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= sq_in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0] <= '0;
      xs_r[0] <= {sq_in_square, 24'b0};
      side_r[0] <= sq_in_side;
    end
  end

  // Digit stages.
  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    sq_t mid, nxt;
    always_comb begin
      mid = sqrt_step(st_r[k], xs_r[k][55:54]);
      nxt = sqrt_step(mid, xs_r[k][53:52]);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (adv) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[k+1] <= nxt;
        xs_r[k+1] <= {xs_r[k][51:0], 4'b0};
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign sq_valid = v_r[SQRT_STAGES];
  assign sq_root = st_r[SQRT_STAGES].root;
  assign sq_side = side_r[SQRT_STAGES];

endmodule

/* src/rmsw_div.sv */
// Pipelined restoring divider of the scaled gradient by root plus epsilon,
// two quotient bits per stage. Depends on rmsw_pkg.
`timescale 1ns / 1ps

module rmsw_div (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            dv_in_valid,
  input  logic [55:0]     dv_in_num,
  input  logic [32:0]     dv_in_den,
  input  rmsw_pkg::side_t dv_in_side,
  output logic            dv_valid,
  output logic [55:0]     dv_quo,
  output rmsw_pkg::side_t dv_side
);
  import rmsw_pkg::*;

  logic        v_r    [0:DIV_STAGES];
  dv_t         st_r   [0:DIV_STAGES];
  logic [32:0] den_r  [0:DIV_STAGES];
  side_t       side_r [0:DIV_STAGES];

  // Load stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= dv_in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0].rem <= '0;
      st_r[0].quo <= dv_in_num;
      den_r[0] <= dv_in_den;
      side_r[0] <= dv_in_side;
    end
  end

  // Quotient stages.
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    dv_t mid, nxt;
    always_comb begin
      mid = div_step(st_r[k], den_r[k]);
      nxt = div_step(mid, den_r[k]);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (adv) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[k+1] <= nxt;
        den_r[k+1] <= den_r[k];
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign dv_valid = v_r[DIV_STAGES];
  assign dv_quo = st_r[DIV_STAGES].quo;
  assign dv_side = side_r[DIV_STAGES];

endmodule

/* src/rmsprop_weight_update.sv */
// RMSProp weight update, top level: configuration registers, step scaling,
// result saturation and output register. Depends on rmsw_pkg, rmsw_msq,
// rmsw_sqrt, rmsw_div and the assertion macro header.
`timescale 1ns / 1ps

// One weight and gradient enter per clock cycle while the output is taken and
// no clearing pass runs, and updated weights leave in the same order through
// the gradient square and mean-square store update, the square root, a
// register that scales the step and adds epsilon, the divider and the output
// register. Back-to-back requests to the same element are forwarded inside the
// store stage, so no element spacing is needed. When the output is not taken,
// the whole pipeline holds. After reset the store is zeroed by a clearing pass
// over every entry, during which in_ready stays low; configuration writes are
// taken at any time and must be made while the pipeline is empty.

`include "rmsprop_weight_update_macros.svh"

module rmsprop_weight_update #(
  parameter int STORE_DEPTH = rmsw_pkg::STORE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [11:0] in_element_index,
  input  logic [31:0] in_weight_in,
  input  logic [31:0] in_gradient,
  input  logic        in_fresh,
  input  logic        in_last_element,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_weight_out,
  output logic [11:0] out_index_out,
  output logic        out_last_out,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import rmsw_pkg::*;

  logic [15:0] decay_r;
  logic [31:0] eps_r;
  logic [23:0] lr_r;
  logic        adv;
  msq_stat_t   stat;

  logic        msq_valid;
  logic [31:0] msq_square;
  side_t       msq_side;
  logic        sq_valid;
  logic [27:0] sq_root;
  side_t       sq_side;
  logic        prep_v_r;
  logic [55:0] num_r;
  logic [32:0] den_r;
  side_t       prep_side_r;
  side_t       prep_side;
  logic [32:0] den;
  logic [55:0] num;
  logic        dv_valid;
  logic [55:0] dv_quo;
  side_t       dv_side;
  logic [57:0] res;
  logic [31:0] res_sat;
  logic        out_valid_r;
  logic [31:0] weight_r;
  logic [11:0] index_r;
  logic        last_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decay_r <= DECAY_RESET;
      eps_r <= EPS_RESET;
      lr_r <= LR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DECAY: decay_r <= cfg_wdata[15:0];
        REG_EPS:   eps_r <= cfg_wdata;
        REG_LR:    lr_r <= cfg_wdata[23:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves whenever the output register can take a result.
  assign adv = !out_valid_r || out_ready;

  rmsw_msq #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_msq (
    .clk             (clk),
    .rst_n           (rst_n),
    .adv             (adv),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_element_index(in_element_index),
    .in_weight_in    (in_weight_in),
    .in_gradient     (in_gradient),
    .in_fresh        (in_fresh),
    .in_last_element (in_last_element),
    .decay_rate      (decay_r),
    .msq_valid       (msq_valid),
    .msq_square      (msq_square),
    .msq_side        (msq_side),
    .stat            (stat)
  );

  rmsw_sqrt u_sqrt (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .sq_in_valid (msq_valid),
    .sq_in_square(msq_square),
    .sq_in_side  (msq_side),
    .sq_valid    (sq_valid),
    .sq_root     (sq_root),
    .sq_side     (sq_side)
  );

  // Step scaling: divisor is root plus epsilon, dividend is lr times |g|.
  always_comb begin
    den = {5'b0, sq_root} + {1'b0, eps_r};
    num = {32'b0, lr_r} * {24'b0, sq_side.mag};
    prep_side = sq_side;
    prep_side.div_zero = (den == 33'd0);
    prep_side.num_zero = (num == 56'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_v_r <= 1'b0;
    end else if (adv) begin
      prep_v_r <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num_r <= num;
      den_r <= den;
      prep_side_r <= prep_side;
    end
  end

  rmsw_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .dv_in_valid(prep_v_r),
    .dv_in_num  (num_r),
    .dv_in_den  (den_r),
    .dv_in_side (prep_side_r),
    .dv_valid   (dv_valid),
    .dv_quo     (dv_quo),
    .dv_side    (dv_side)
  );

  // Apply the step with the gradient's sign and saturate to Q8.24.
  always_comb begin
    if (dv_side.neg) begin
      res = {{26{dv_side.weight[31]}}, dv_side.weight} + {2'b0, dv_quo};
    end else begin
      res = {{26{dv_side.weight[31]}}, dv_side.weight} - {2'b0, dv_quo};
    end
    if (dv_side.div_zero) begin
      if (dv_side.num_zero) begin
        res_sat = dv_side.weight;
      end else if (dv_side.neg) begin
        res_sat = 32'h7FFF_FFFF;
      end else begin
        res_sat = 32'h8000_0000;
      end
    end else if (res[57] && !(&res[56:31])) begin
      res_sat = 32'h8000_0000;
    end else if (!res[57] && (|res[56:31])) begin
      res_sat = 32'h7FFF_FFFF;
    end else begin
      res_sat = res[31:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      weight_r <= res_sat;
      index_r <= dv_side.idx;
      last_r <= dv_side.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_weight_out = weight_r;
  assign out_index_out = index_r;
  assign out_last_out = last_r;

  // No request is taken while the store is being cleared.
  `RMSW_ASSERT_IMP(a_no_req_clear, clk, rst_n, stat.clearing, !in_ready, "request during clear")
  // A stalled output freezes the pipeline.
  `RMSW_ASSERT_NXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, $stable(prep_v_r) && $stable(num_r), "pipeline moved during stall")
  // Once clearing ends, readiness follows the output side alone.
  `RMSW_ASSERT_IMP(a_ready_adv, clk, rst_n, !stat.clearing, in_ready == adv, "ready not tied to advance")

endmodule

/* test/tb_rmsprop_weight_update.sv */
// Self-checking testbench for the RMSProp weight update block.
// Depends on rmsw_pkg and the rmsprop_weight_update top level.
`timescale 1ns / 1ps

module tb_rmsprop_weight_update;
  import rmsw_pkg::*;

  localparam int DEPTH = 4096;
  localparam int LATENCY = 49;
  localparam int STALL_LIMIT = 20000;

  // One expected weight update.
  typedef struct packed {
    logic [31:0] weight;
    logic [11:0] idx;
    logic        last;
  } update_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [11:0] in_element_index;
  logic [31:0] in_weight_in;
  logic [31:0] in_gradient;
  logic        in_fresh;
  logic        in_last_element;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_weight_out;
  logic [11:0] out_index_out;
  logic        out_last_out;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;

  // Predictor state: registers and the mean-square table.
  logic [15:0] rho_q;
  logic [31:0] eps_q;
  logic [23:0] lr_q;
  logic [31:0] msq_table [DEPTH];

  update_t expected_updates[$];
  int      error_count;
  int      idle_cycles;
  bit      no_idle;
  int      out_idle_pct;

  rmsprop_weight_update u_top (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bit-serial integer square root of a 64-bit value.
  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bitv;
    res = '0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Computes the updated weight and advances the mean-square table.
  function automatic update_t rmsprop_update(input logic [11:0] idx,
                                             input logic [31:0] w,
                                             input logic [31:0] g,
                                             input logic fresh,
                                             input logic last);
    update_t u;
    logic        neg;
    logic [63:0] mag;
    logic [63:0] gsq;
    logic [63:0] old_s;
    logic [63:0] sum;
    logic [63:0] s_new;
    logic [63:0] d;
    logic [63:0] num;
    longint      res;
    neg = g[31];
    mag = neg ? 64'(-$signed({32'hFFFFFFFF, g})) : {32'd0, g};
    gsq = (mag * mag) >> 24;
    if (gsq > 64'hFFFFFFFF) gsq = 64'hFFFFFFFF;
    old_s = fresh ? 64'd0 : {32'd0, msq_table[idx % DEPTH]};
    sum = 64'(rho_q) * old_s + (64'd65536 - 64'(rho_q)) * gsq;
    s_new = sum >> 16;
    if (s_new > 64'hFFFFFFFF) s_new = 64'hFFFFFFFF;
    msq_table[idx % DEPTH] = s_new[31:0];
    d = int_sqrt(s_new << 24) + 64'(eps_q);
    num = 64'(lr_q) * mag;
    if (d == 0) begin
      if (num == 0) res = longint'($signed(w));
      else res = neg ? 64'sd2147483647 : -64'sd2147483648;
    end else begin
      res = neg ? longint'($signed(w)) + longint'(num / d)
                : longint'($signed(w)) - longint'(num / d);
      if (res > 64'sd2147483647) res = 64'sd2147483647;
      if (res < -64'sd2147483648) res = -64'sd2147483648;
    end
    u.weight = res[31:0];
    u.idx = idx;
    u.last = last;
    return u;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Random gaps on the request side, skipped in the no-idle stretch.
  task automatic idle_gap();
    while (!no_idle && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  // Sends one request and records its expected update on acceptance.
  // Valid stays high afterwards so that the next request can follow at once.
  task automatic send_request(input logic [11:0] idx, input logic [31:0] w,
                              input logic [31:0] g, input logic fresh,
                              input logic last);
    idle_gap();
    in_valid <= 1'b1;
    in_element_index <= idx;
    in_weight_in <= w;
    in_gradient <= g;
    in_fresh <= fresh;
    in_last_element <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_updates.push_back(rmsprop_update(idx, w, g, fresh, last));
    @(negedge clk);
  endtask

  // Waits until the pipeline is empty, then writes one register.
  task automatic write_reg(input reg_idx_t r, input logic [31:0] v);
    in_valid <= 1'b0;
    while (expected_updates.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (r)
      REG_DECAY: rho_q = v[15:0];
      REG_EPS:   eps_q = v;
      REG_LR:    lr_q = v[23:0];
      default:   ;
    endcase
  endtask

  task automatic set_config(input logic [15:0] rho, input logic [31:0] eps,
                            input logic [23:0] lr);
    write_reg(REG_DECAY, {16'd0, rho});
    write_reg(REG_EPS, eps);
    write_reg(REG_LR, {8'd0, lr});
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom_range(32'h00FFFFFF);
      2: return -$urandom_range(32'h00FFFFFF);
      default: return $urandom_range(32'h0FFFFFFF) - 32'h08000000;
    endcase
  endfunction

  // Field extremes at reset settings, the zero-divisor cases with eps 0, and a decay of zero.
  task automatic test_directed();
    send_request(12'd0, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1, 1'b0);
    send_request(12'd4095, 32'h80000000, 32'h80000000, 1'b1, 1'b1);
    send_request(12'd0, 32'h80000000, 32'h7FFFFFFF, 1'b0, 1'b0);
    send_request(12'd4095, 32'h7FFFFFFF, 32'h80000000, 1'b0, 1'b1);
    send_request(12'd7, 32'h01000000, 32'h00000000, 1'b1, 1'b0);
    send_request(12'd7, 32'h01000000, 32'h00000001, 1'b0, 1'b0);
    send_request(12'd7, 32'hFF000000, 32'hFFFFFFFF, 1'b0, 1'b1);
    send_request(12'd8, 32'h00000000, 32'h01000000, 1'b1, 1'b0);
    send_request(12'd8, 32'h00000000, 32'hFF000000, 1'b0, 1'b1);
    // Zero divisor: eps zero and a mean square of zero.
    set_config(16'hFFFF, 32'd0, 24'hFFFFFF);
    send_request(12'd100, 32'h12345678, 32'h00000000, 1'b1, 1'b0);
    send_request(12'd101, 32'h12345678, 32'h00000001, 1'b1, 1'b0);
    send_request(12'd102, 32'h12345678, 32'hFFFFFFFF, 1'b1, 1'b1);
    send_request(12'd103, 32'h00000000, 32'h00000100, 1'b1, 1'b0);
    // Decay of zero takes only the new square; full step size.
    set_config(16'd0, 32'hFFFFFFFF, 24'hFFFFFF);
    send_request(12'd200, 32'h00ABCDEF, 32'h00800000, 1'b1, 1'b0);
    send_request(12'd200, 32'hFFABCDEF, 32'hFF800000, 1'b0, 1'b1);
    send_request(12'd201, 32'h7FFFFFFF, 32'h80000000, 1'b1, 1'b0);
  endtask

  // Random tensors with runs of indexes, including back-to-back repeats.
  task automatic test_random(input int count);
    logic [11:0] base;
    int n;
    int k;
    n = 0;
    while (n < count) begin
      base = $urandom();
      k = $urandom_range(1, 24);
      for (int i = 0; i < k; i++) begin
        send_request($urandom_range(3) == 0 ? base : base + i[11:0], rand_value(),
                     rand_value(), $urandom_range(7) == 0, i == k - 1);
        n++;
      end
    end
  endtask

  // Several register settings, extremes among them.
  task automatic test_settings();
    set_config(16'd58982, 32'd1, 24'd16777);
    test_random(400);
    no_idle = 1'b1;
    out_idle_pct = 0;
    test_random(300);
    no_idle = 1'b0;
    out_idle_pct = 34;
    set_config(16'hFFFF, 32'hFFFFFFFF, 24'd0);
    test_random(150);
    set_config(16'd0, 32'd0, 24'hFFFFFF);
    test_random(300);
    set_config(16'($urandom()), $urandom(), 24'($urandom()));
    test_random(250);
    set_config(16'd32768, 32'h01000000, 24'h800000);
    test_random(200);
  endtask

  // Result side: random back-pressure and comparison against the oldest update.
  always @(negedge clk) out_ready <= ($urandom_range(99) >= out_idle_pct);

  always @(posedge clk) begin
    update_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_updates.size() == 0) begin
        report_mismatch("unexpected update", out_weight_out, 32'd0);
      end else begin
        want = expected_updates.pop_front();
        if (out_weight_out !== want.weight)
          report_mismatch("weight_out", out_weight_out, want.weight);
        if (out_index_out !== want.idx)
          report_mismatch("index_out", {20'd0, out_index_out}, {20'd0, want.idx});
        if (out_last_out !== want.last)
          report_mismatch("last_out", {31'd0, out_last_out}, {31'd0, want.last});
      end
    end
  end

  // Watchdog on cycles with no accepted request or update.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_element_index = '0;
    in_weight_in = '0;
    in_gradient = '0;
    in_fresh = 1'b0;
    in_last_element = 1'b0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_DECAY;
    cfg_wdata = '0;
    error_count = 0;
    idle_cycles = 0;
    no_idle = 1'b0;
    out_idle_pct = 34;
    rho_q = DECAY_RESET;
    eps_q = EPS_RESET;
    lr_q = LR_RESET;
    for (int i = 0; i < DEPTH; i++) msq_table[i] = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_settings();
    in_valid <= 1'b0;
    while (expected_updates.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
